// ===== rtl/dmc_pkg.sv =====
// Shared types, codes and helper functions for the door motor controller.
package dmc_pkg;

	localparam int TIMER_BITS = 16;

	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_OPEN        = 3'd1;
	localparam logic [2:0] CMD_SAFE_CLOSE  = 3'd2;
	localparam logic [2:0] CMD_FORCE_CLOSE = 3'd3;
	localparam logic [2:0] CMD_CLEAR       = 3'd4;
	localparam logic [2:0] CMD_INIT        = 3'd5;

	localparam logic [2:0] DOOR_CLOSED  = 3'd0;
	localparam logic [2:0] DOOR_OPENED  = 3'd1;
	localparam logic [2:0] DOOR_OPENING = 3'd2;
	localparam logic [2:0] DOOR_SAFE    = 3'd3;
	localparam logic [2:0] DOOR_FORCE   = 3'd4;

	localparam logic [1:0] MOT_STANDBY = 2'd0;
	localparam logic [1:0] MOT_FWD     = 2'd1;
	localparam logic [1:0] MOT_BWD     = 2'd2;
	localparam logic [1:0] MOT_SUSP    = 2'd3;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_PROGRESS = 3'd1;
	localparam logic [2:0] ST_DONE     = 3'd2;
	localparam logic [2:0] ST_SAME     = 3'd3;
	localparam logic [2:0] ST_BLOCKED  = 3'd4;

	localparam logic [1:0] REG_STEP_TIME   = 2'd0;
	localparam logic [1:0] REG_CONF_WAIT   = 2'd1;
	localparam logic [1:0] REG_MOTOR_SPEED = 2'd2;

	localparam logic [15:0] STEP_TIME_RESET   = 16'd1000;
	localparam logic [15:0] CONF_WAIT_RESET   = 16'd500;
	localparam logic [7:0]  MOTOR_SPEED_RESET = 8'd255;

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [4:0] {
		MODE_CLOSED  = 5'b00001,
		MODE_OPENED  = 5'b00010,
		MODE_OPENING = 5'b00100,
		MODE_SAFE    = 5'b01000,
		MODE_FORCE   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [15:0] step_time;
		logic [15:0] conf_wait;
		logic [7:0]  speed;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        conf_act;
		logic        conf_tgt;
		logic [1:0]  motor;
		logic        laser;
		logic [2:0]  last;
		timer_t      step_tmr;
		timer_t      conf_tmr;
		timer_t      ord_tmr;
	} st_t;

	function automatic logic [2:0] mode_code(mode_t m);
		logic [2:0] c;
		case (m)
			MODE_CLOSED:  c = DOOR_CLOSED;
			MODE_OPENED:  c = DOOR_OPENED;
			MODE_OPENING: c = DOOR_OPENING;
			MODE_SAFE:    c = DOOR_SAFE;
			default:      c = DOOR_FORCE;
		endcase
		return c;
	endfunction

	function automatic timer_t sat_inc(timer_t t);
		return (t == '1) ? t : t + timer_t'(1);
	endfunction

	// Elapsed time as shown on the port: saturated to sixteen bits.
	function automatic logic [15:0] elapsed_out(timer_t t);
		logic [31:0] w;
		w = 32'(t);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

// ===== rtl/dmc_cfg_regs.sv =====
// Configuration registers of the door motor controller.
module dmc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output dmc_pkg::cfg_t     cfg
);

	dmc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time <= dmc_pkg::STEP_TIME_RESET;
			cfg_q.conf_wait <= dmc_pkg::CONF_WAIT_RESET;
			cfg_q.speed     <= dmc_pkg::MOTOR_SPEED_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dmc_pkg::REG_STEP_TIME:   cfg_q.step_time <= cfg_data;
				dmc_pkg::REG_CONF_WAIT:   cfg_q.conf_wait <= cfg_data;
				dmc_pkg::REG_MOTOR_SPEED: cfg_q.speed     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/dmc_fsm.sv =====
// Door state registers and the next-state logic for one item.
module dmc_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [2:0]    cmd,
	input  logic          closed_sw,
	input  logic          opened_sw,
	input  logic          beam,
	input  dmc_pkg::cfg_t cfg,
	output dmc_pkg::st_t  nxt
);

	dmc_pkg::st_t st_q;

	// Ends a confirmation wait: stop on a held switch, otherwise resume.
	function automatic dmc_pkg::st_t resolve(dmc_pkg::st_t s, logic c_sw, logic o_sw);
		dmc_pkg::st_t r;
		logic hit;
		r = s;
		hit = s.conf_tgt ? o_sw : c_sw;
		r.conf_act = 1'b0;
		r.conf_tmr = '0;
		if (!hit) begin
			r.motor = (s.mode == dmc_pkg::MODE_OPENING) ? dmc_pkg::MOT_BWD : dmc_pkg::MOT_FWD;
		end else begin
			r.motor = dmc_pkg::MOT_STANDBY;
			r.laser = 1'b0;
			r.mode  = s.conf_tgt ? dmc_pkg::MODE_OPENED : dmc_pkg::MODE_CLOSED;
			if (s.last != dmc_pkg::ST_NONE) begin
				r.last = dmc_pkg::ST_DONE;
			end
		end
		return r;
	endfunction

	function automatic dmc_pkg::st_t start_conf(dmc_pkg::st_t s, logic tgt);
		dmc_pkg::st_t r;
		r = s;
		r.conf_act = 1'b1;
		r.conf_tgt = tgt;
		r.conf_tmr = '0;
		r.motor    = dmc_pkg::MOT_SUSP;
		return r;
	endfunction

	always_comb begin
		nxt = st_q;
		case (cmd)
			dmc_pkg::CMD_TICK: begin
				nxt.step_tmr = dmc_pkg::sat_inc(st_q.step_tmr);
				nxt.ord_tmr  = dmc_pkg::sat_inc(st_q.ord_tmr);
				if (st_q.conf_act) begin
					nxt.conf_tmr = dmc_pkg::sat_inc(st_q.conf_tmr);
					if (32'(nxt.conf_tmr) >= 32'(cfg.conf_wait)) begin
						nxt = resolve(nxt, closed_sw, opened_sw);
					end
				end else begin
					case (st_q.mode)
						dmc_pkg::MODE_OPENING: begin
							if (opened_sw) begin
								nxt = start_conf(nxt, 1'b1);
							end
						end
						dmc_pkg::MODE_SAFE: begin
							if (closed_sw) begin
								nxt = start_conf(nxt, 1'b0);
							end else if (32'(nxt.step_tmr) >= 32'(cfg.step_time)) begin
								if (beam) begin
									nxt.motor    = dmc_pkg::MOT_FWD;
									nxt.step_tmr = '0;
								end else begin
									nxt.motor = dmc_pkg::MOT_BWD;
									nxt.mode  = dmc_pkg::MODE_OPENING;
								end
							end
						end
						dmc_pkg::MODE_FORCE: begin
							if (closed_sw) begin
								nxt = start_conf(nxt, 1'b0);
							end
						end
						default: ;
					endcase
					// A zero wait is settled within the same tick.
					if (nxt.conf_act && cfg.conf_wait == 16'd0) begin
						nxt = resolve(nxt, closed_sw, opened_sw);
					end
				end
			end
			dmc_pkg::CMD_OPEN, dmc_pkg::CMD_SAFE_CLOSE,
			dmc_pkg::CMD_FORCE_CLOSE, dmc_pkg::CMD_CLEAR: begin
				if (!st_q.conf_act) begin
					nxt.last = dmc_pkg::ST_NONE;
					if (cmd != dmc_pkg::CMD_CLEAR) begin
						nxt.ord_tmr = '0;
					end
					if (cmd == dmc_pkg::CMD_OPEN) begin
						if (opened_sw) begin
							nxt.last = dmc_pkg::ST_SAME;
						end else begin
							nxt.mode  = dmc_pkg::MODE_OPENING;
							nxt.last  = dmc_pkg::ST_PROGRESS;
							nxt.motor = dmc_pkg::MOT_BWD;
						end
					end else if (cmd == dmc_pkg::CMD_SAFE_CLOSE) begin
						if (closed_sw) begin
							nxt.last = dmc_pkg::ST_SAME;
						end else if (!beam) begin
							nxt.last = dmc_pkg::ST_BLOCKED;
						end else begin
							nxt.laser    = 1'b1;
							nxt.mode     = dmc_pkg::MODE_SAFE;
							nxt.last     = dmc_pkg::ST_PROGRESS;
							nxt.step_tmr = '0;
							nxt.motor    = dmc_pkg::MOT_FWD;
						end
					end else if (cmd == dmc_pkg::CMD_FORCE_CLOSE) begin
						if (closed_sw) begin
							nxt.last = dmc_pkg::ST_SAME;
						end else begin
							nxt.mode  = dmc_pkg::MODE_FORCE;
							nxt.last  = dmc_pkg::ST_PROGRESS;
							nxt.motor = dmc_pkg::MOT_FWD;
						end
					end
				end
			end
			dmc_pkg::CMD_INIT: begin
				if (closed_sw) begin
					nxt.mode = dmc_pkg::MODE_CLOSED;
				end else if (opened_sw) begin
					nxt.mode = dmc_pkg::MODE_OPENED;
				end else begin
					nxt.mode = dmc_pkg::MODE_FORCE;
				end
				nxt.conf_act = 1'b0;
				nxt.conf_tmr = '0;
				nxt.motor    = dmc_pkg::MOT_STANDBY;
				nxt.laser    = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode     <= dmc_pkg::MODE_FORCE;
			st_q.conf_act <= 1'b0;
			st_q.conf_tgt <= 1'b0;
			st_q.motor    <= dmc_pkg::MOT_STANDBY;
			st_q.laser    <= 1'b0;
			st_q.last     <= dmc_pkg::ST_NONE;
			st_q.step_tmr <= '0;
			st_q.conf_tmr <= '0;
			st_q.ord_tmr  <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

endmodule

// ===== rtl/door_motor_controller_top.sv =====
// Top level of the door motor controller: input register, state update and result register.
// Latency: two register stages; an accepted item is held in the input register, and its
// result in the result register, held there while the result side stalls. Throughput is
// one item per cycle unless the result side stalls, set by the combinational state update.
// Reset is asynchronous and active low: the door is taken as force closing with the motor
// in standby, all timers cleared and the configuration registers back at their defaults.
module door_motor_controller_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  cmd,
	input  logic        closed_switch,
	input  logic        opened_switch,
	input  logic        beam_clear,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  door_state,
	output logic        confirming,
	output logic [1:0]  motor_drive,
	output logic [7:0]  drive_level,
	output logic        laser_on,
	output logic [2:0]  order_status,
	output logic [15:0] order_elapsed_ms,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// The input register holds one accepted item until the state update can
	// take it, which is whenever the result register is empty or being drained.
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic        closed_s1;
	logic        opened_s1;
	logic        beam_s1;

	logic        out_free;
	logic        advance;
	logic        result_valid_q;

	dmc_pkg::cfg_t cfg;
	dmc_pkg::st_t  nxt;

	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	// The input register can take a new transaction when it is empty or moves on.
	assign item_stall = valid_s1 && !out_free;

	dmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dmc_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cmd       (cmd_s1),
		.closed_sw (closed_s1),
		.opened_sw (opened_s1),
		.beam      (beam_s1),
		.cfg       (cfg),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1    <= cmd;
			closed_s1 <= closed_switch;
			opened_s1 <= opened_switch;
			beam_s1   <= beam_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	// The result shows the state after the item; the drive level is only
	// applied while the motor actually turns in one direction or the other.
	always_ff @(posedge clk) begin
		if (advance) begin
			door_state       <= dmc_pkg::mode_code(nxt.mode);
			confirming       <= nxt.conf_act;
			motor_drive      <= nxt.motor;
			drive_level      <= (nxt.motor == dmc_pkg::MOT_FWD || nxt.motor == dmc_pkg::MOT_BWD)
			                    ? cfg.speed : 8'd0;
			laser_on         <= nxt.laser;
			order_status     <= nxt.last;
			order_elapsed_ms <= dmc_pkg::elapsed_out(nxt.ord_tmr);
		end
	end

	assign result_valid = result_valid_q;

endmodule
